FILE: src/pkn_pkg.sv
// ----------------------------------------------------------------------------
// pkn_pkg
// Shared types and constants for the path key normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pkn_pkg;

  localparam int CountWidth = 16;
  localparam int CmpWidth   = (CountWidth + 1 > 17) ? CountWidth + 1 : 17;
  localparam int QueueDepth = 8;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int MaxPush    = 4;

  localparam logic [7:0] ChSlash = 8'd47;
  localparam logic [7:0] ChDot   = 8'd46;
  localparam logic [7:0] ChEnd   = 8'd0;

  localparam logic [15:0] CapacityReset = 16'd1024;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TRAVERSAL = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_DOT1    = 2'd1,
    PH_DOT2    = 2'd2,
    PH_INSIDE  = 2'd3
  } phase_t;

  typedef enum logic {
    REG_KEY_CAPACITY = 1'b0,
    REG_UNUSED       = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] key_byte;
    status_t    status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [2:0]                 count;
    result_t [MaxPush-1:0]      item;
  } push_t;

endpackage

`default_nettype wire

FILE: src/pkn_step.sv
// ----------------------------------------------------------------------------
// pkn_step
// Segment state machine: turns one path byte into up to four results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkn_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [7:0]    path_byte,
  input  wire logic [15:0]   key_capacity,
  output pkn_pkg::push_t     push
);
  import pkn_pkg::*;

  phase_t                  phase, phase_next;
  status_t                 sticky, sticky_next;
  logic [CountWidth-1:0]   written, written_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_BETWEEN;
      sticky  <= ST_OK;
      written <= '0;
    end else if (go) begin
      phase   <= phase_next;
      sticky  <= sticky_next;
      written <= written_next;
    end
  end

  always_comb begin
    logic [7:0]           cand [MaxPush];
    logic [2:0]           ncand;
    logic [2:0]           emitted;
    logic                 ends;
    logic                 is_dot;
    logic                 lead;
    logic [CmpWidth-1:0]  nxt;
    logic [CmpWidth-1:0]  cap;

    for (int i = 0; i < MaxPush; i++) begin
      cand[i] = ChSlash;
    end
    ncand        = 3'd0;
    emitted      = 3'd0;
    ends         = (path_byte == ChEnd) || (path_byte == ChSlash);
    is_dot       = (path_byte == ChDot);
    lead         = (written != '0);
    cap          = CmpWidth'(key_capacity);
    nxt          = '0;
    phase_next   = phase;
    sticky_next  = sticky;
    written_next = written;
    push         = '0;

    if (sticky == ST_OK) begin
      unique case (phase)
        PH_BETWEEN: begin
          if (is_dot) begin
            phase_next = PH_DOT1;
          end else if (!ends) begin
            if (lead) begin
              ncand = ncand + 3'd1;
            end
            cand[ncand[1:0]] = path_byte;
            ncand = ncand + 3'd1;
            phase_next = PH_INSIDE;
          end
        end
        PH_DOT1: begin
          if (ends) begin
            phase_next = PH_BETWEEN;
          end else if (is_dot) begin
            phase_next = PH_DOT2;
          end else begin
            if (lead) begin
              ncand = ncand + 3'd1;
            end
            cand[ncand[1:0]] = ChDot;
            ncand = ncand + 3'd1;
            cand[ncand[1:0]] = path_byte;
            ncand = ncand + 3'd1;
            phase_next = PH_INSIDE;
          end
        end
        PH_DOT2: begin
          if (ends) begin
            sticky_next = ST_TRAVERSAL;
            phase_next  = PH_BETWEEN;
          end else begin
            if (lead) begin
              ncand = ncand + 3'd1;
            end
            cand[ncand[1:0]] = ChDot;
            ncand = ncand + 3'd1;
            cand[ncand[1:0]] = ChDot;
            ncand = ncand + 3'd1;
            cand[ncand[1:0]] = path_byte;
            ncand = ncand + 3'd1;
            phase_next = PH_INSIDE;
          end
        end
        PH_INSIDE: begin
          if (ends) begin
            phase_next = PH_BETWEEN;
          end else begin
            cand[0] = path_byte;
            ncand   = 3'd1;
          end
        end
        default: begin
          phase_next = PH_BETWEEN;
        end
      endcase
    end

    // one capacity check per candidate byte; first failure stops the rest
    for (int i = 0; i < MaxPush; i++) begin
      if ((3'(i) < ncand) && (sticky_next == ST_OK)) begin
        nxt = CmpWidth'(written_next) + CmpWidth'(1);
        if ((nxt >= cap) || (nxt > CmpWidth'({CountWidth{1'b1}}))) begin
          sticky_next = ST_TOO_LONG;
        end else begin
          written_next = nxt[CountWidth-1:0];
          push.item[emitted[1:0]].is_status = 1'b0;
          push.item[emitted[1:0]].key_byte  = cand[i];
          push.item[emitted[1:0]].status    = ST_OK;
          push.item[emitted[1:0]].last      = 1'b0;
          emitted = emitted + 3'd1;
        end
      end
    end

    if (path_byte == ChEnd) begin
      push.item[emitted[1:0]].is_status = 1'b1;
      push.item[emitted[1:0]].key_byte  = 8'd0;
      push.item[emitted[1:0]].last      = 1'b1;
      priority if (key_capacity == 16'd0) begin
        push.item[emitted[1:0]].status = ST_EMPTY;
      end else if (sticky_next != ST_OK) begin
        push.item[emitted[1:0]].status = sticky_next;
      end else if (written_next == '0) begin
        push.item[emitted[1:0]].status = ST_EMPTY;
      end else begin
        push.item[emitted[1:0]].status = ST_OK;
      end
      emitted      = emitted + 3'd1;
      phase_next   = PH_BETWEEN;
      sticky_next  = ST_OK;
      written_next = '0;
    end

    push.count = go ? emitted : 3'd0;
  end

endmodule

`default_nettype wire

FILE: src/pkn_queue.sv
// ----------------------------------------------------------------------------
// pkn_queue
// Result queue: takes up to four results a cycle, hands out one a cycle while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkn_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pkn_pkg::push_t push,
  output logic               has_room,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pkn_pkg::result_t   head
);
  import pkn_pkg::*;

  result_t                 entry [QueueDepth];
  logic [QueuePtrW-1:0]    wptr;
  logic [QueuePtrW-1:0]    rptr;
  logic [QueuePtrW:0]      fill;
  logic                    pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (fill != '0);
  assign has_room  = (fill <= (QueuePtrW+1)'(QueueDepth - MaxPush));
  assign head      = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + QueuePtrW'(push.count);
      rptr <= rptr + QueuePtrW'(pop);
      fill <= fill + (QueuePtrW+1)'(push.count) - (QueuePtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    logic [QueuePtrW-1:0] offs;
    for (int i = 0; i < QueueDepth; i++) begin
      offs = QueuePtrW'(i) - wptr;
      if ((QueuePtrW+1)'(offs) < (QueuePtrW+1)'(push.count)) begin
        entry[i] <= push.item[offs[1:0]];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/path_key_normalizer.sv
// ----------------------------------------------------------------------------
// path_key_normalizer
// Path to storage key normalizer with sticky error status.
// ----------------------------------------------------------------------------
// Takes one path byte per cycle into an input register; the segment logic
// turns it into up to four results (separator, held dots, the byte, or the
// final status) and writes them into an eight-entry result queue in the same
// cycle. Results leave one per cycle while out_stall is low; plain bytes
// inside a segment run at one per cycle. The input register waits while the
// queue has fewer than four free entries. Bytes pass the input register, then
// the queue. key_capacity is written through the register port; the user must
// do so only while no path is in flight, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module path_key_normalizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  path_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_status,
  output logic [7:0]       key_byte,
  output logic [1:0]       status,
  output logic             last
);
  import pkn_pkg::*;

  logic [15:0]  key_capacity;
  logic         stage_valid;
  logic [7:0]   stage_byte;
  logic         has_room;
  logic         advance;
  logic         accept;
  push_t        push;
  result_t      head;
  reg_index_t   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign prdata  = (reg_sel == REG_KEY_CAPACITY) ? {16'd0, key_capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_capacity <= CapacityReset;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_KEY_CAPACITY)) begin
      key_capacity <= pwdata[15:0];
    end
  end

  assign advance  = stage_valid && has_room;
  assign in_stall = stage_valid && !has_room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte <= path_byte;
    end
  end

  pkn_step u_step (
    .clk          (clk),
    .rst          (rst),
    .go           (advance),
    .path_byte    (stage_byte),
    .key_capacity (key_capacity),
    .push         (push)
  );

  pkn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign is_status = head.is_status;
  assign key_byte  = head.key_byte;
  assign status    = head.status;
  assign last      = head.last;

endmodule

`default_nettype wire

FILE: test/pkn_checker.sv
// ----------------------------------------------------------------------------
// pkn_checker
// Watches the register port and both request channels of the path key
// normalizer, predicts the key bytes and final status of every path, and
// compares each result request field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkn_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  path_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        is_status,
  input  wire logic [7:0]  key_byte,
  input  wire logic [1:0]  status,
  input  wire logic        last,
  output int               fail_count,
  output int               pending
);
  import pkn_pkg::*;

  localparam longint unsigned CountMax = (64'd1 << CountWidth) - 64'd1;

  logic [15:0]     capacity;
  phase_t          seg;
  longint unsigned key_len;
  status_t         err;
  result_t         key_queue[$];

  task automatic push_key(input logic [7:0] b);
    longint unsigned nxt;
    result_t r;
    if (err != ST_OK) return;
    nxt = key_len + 1;
    if (nxt >= capacity || nxt > CountMax) begin
      err = ST_TOO_LONG;
      return;
    end
    key_len = nxt;
    r.is_status = 1'b0;
    r.key_byte = b;
    r.status = ST_OK;
    r.last = 1'b0;
    key_queue.push_back(r);
  endtask

  // separator only once something is already in the key
  task automatic start_segment();
    if (key_len > 0) push_key(ChSlash);
  endtask

  task automatic normalize_byte(input logic [7:0] b);
    logic ends;
    result_t r;
    ends = (b == ChEnd) || (b == ChSlash);
    if (err == ST_OK) begin
      case (seg)
        PH_BETWEEN: begin
          if (b == ChDot) begin
            seg = PH_DOT1;
          end else if (!ends) begin
            start_segment();
            push_key(b);
            seg = PH_INSIDE;
          end
        end
        PH_DOT1: begin
          if (ends) begin
            seg = PH_BETWEEN;
          end else if (b == ChDot) begin
            seg = PH_DOT2;
          end else begin
            start_segment();
            push_key(ChDot);
            push_key(b);
            seg = PH_INSIDE;
          end
        end
        PH_DOT2: begin
          if (ends) begin
            err = ST_TRAVERSAL;
            seg = PH_BETWEEN;
          end else begin
            start_segment();
            push_key(ChDot);
            push_key(ChDot);
            push_key(b);
            seg = PH_INSIDE;
          end
        end
        default: begin
          if (ends) seg = PH_BETWEEN;
          else push_key(b);
        end
      endcase
    end
    if (b == ChEnd) begin
      r.is_status = 1'b1;
      r.key_byte = 8'd0;
      r.last = 1'b1;
      if (capacity == 16'd0) r.status = ST_EMPTY;
      else if (err != ST_OK) r.status = err;
      else if (key_len == 0) r.status = ST_EMPTY;
      else r.status = ST_OK;
      key_queue.push_back(r);
      seg = PH_BETWEEN;
      key_len = 0;
      err = ST_OK;
    end
  endtask

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
               act_val);
      fail_count = fail_count + 1;
    end
  endtask

  task automatic check_result();
    result_t e;
    if (key_queue.size() == 0) begin
      $display("%0t: unexpected result, actual is_status %0h key_byte %0h status %0h last %0h",
               $time, is_status, key_byte, status, last);
      fail_count = fail_count + 1;
      return;
    end
    e = key_queue.pop_front();
    report_field("is_status", int'(e.is_status), int'(is_status));
    report_field("key_byte", int'(e.key_byte), int'(key_byte));
    report_field("status", int'(e.status), int'(status));
    report_field("last", int'(e.last), int'(last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity = CapacityReset;
      seg = PH_BETWEEN;
      key_len = 0;
      err = ST_OK;
      key_queue.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_KEY_CAPACITY, 2'b00})
        capacity = pwdata[15:0];
      if (in_valid && !in_stall) normalize_byte(path_byte);
      if (out_valid && !out_stall) check_result();
      pending <= key_queue.size();
    end
  end

endmodule

FILE: test/tb_path_key_normalizer.sv
// ----------------------------------------------------------------------------
// tb_path_key_normalizer
// Drives paths into the path key normalizer under several key capacities and
// three idle patterns: a short directed set of paths first, then random
// well-formed paths with some noise; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_path_key_normalizer;
  import pkn_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  path_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_status;
  logic [7:0]  key_byte;
  logic [1:0]  status;
  logic        last;

  int fails;
  int pending_results;
  int gap_pct = 0;
  int stall_pct = 0;
  logic [7:0] path_buf[$];

  path_key_normalizer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .path_byte(path_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_status(is_status), .key_byte(key_byte), .status(status), .last(last)
  );

  pkn_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .path_byte(path_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_status(is_status), .key_byte(key_byte), .status(status), .last(last),
    .fail_count(fails), .pending(pending_results)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL path_key_normalizer");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    path_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(ChEnd);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_KEY_CAPACITY, 2'b00};
    pwdata <= {16'd0, cap};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_name();
    logic [7:0] b;
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(1, 255)); while (b == ChSlash);
      path_buf.push_back(b);
    end
  endtask

  task automatic make_path();
    int nseg;
    int kind;
    path_buf.delete();
    if ($urandom_range(99) < 80) begin
      repeat ($urandom_range(0, 2)) path_buf.push_back(ChSlash);
      nseg = $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) repeat ($urandom_range(1, 3)) path_buf.push_back(ChSlash);
        kind = $urandom_range(19);
        if (kind < 2) begin
          path_buf.push_back(ChDot);
        end else if (kind == 2) begin
          path_buf.push_back(ChDot);
          path_buf.push_back(ChDot);
        end else if (kind < 5) begin
          repeat ($urandom_range(1, 3)) path_buf.push_back(ChDot);
          add_name();
        end else begin
          add_name();
        end
      end
      if ($urandom_range(3) == 0) path_buf.push_back(ChSlash);
    end else begin
      // noise, biased toward dots and slashes
      repeat ($urandom_range(1, 8)) begin
        kind = $urandom_range(3);
        if (kind == 0) path_buf.push_back(ChDot);
        else if (kind == 1) path_buf.push_back(ChSlash);
        else path_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    path_buf.push_back(ChEnd);
  endtask

  int gap_by_mode[3] = '{33, 56, 0};
  int stall_by_mode[3] = '{56, 33, 0};
  logic [15:0] cap_by_phase[6] = '{16'd6, 16'd65535, 16'd0, 16'd3, 16'd17, 16'd1};

  initial begin
    int phase_items;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    gap_pct = gap_by_mode[0];
    stall_pct = stall_by_mode[0];

    send_text("a");
    send_text("");
    send_text("x//y/");
    send_text("./a");
    send_text("..");
    send_text(".b/..c");
    send_text("\377\001");

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      gap_pct = gap_by_mode[p / 2];
      stall_pct = stall_by_mode[p / 2];
      write_capacity(cap_by_phase[p]);
      phase_items = 0;
      while (phase_items < 60) begin
        make_path();
        phase_items += path_buf.size();
        foreach (path_buf[i]) send_byte(path_buf[i]);
      end
    end

    wait_idle();
    if (fails == 0 && pending_results == 0) begin
      $display("PASS path_key_normalizer");
    end else begin
      $display("FAIL path_key_normalizer");
    end
    $finish;
  end

endmodule

FILE: files.f
src/pkn_pkg.sv
src/pkn_step.sv
src/pkn_queue.sv
src/path_key_normalizer.sv
test/pkn_checker.sv
test/tb_path_key_normalizer.sv
